/* hdl/dtq_pkg.sv */
`default_nettype none
package dtq_pkg;

  localparam int DEPTH   = 32;
  localparam int MAX_OUT = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POP_W = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] client;
    logic [15:0] tag;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* hdl/dtq_cell.sv */
`default_nettype none
module dtq_cell
  import dtq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_cmd_t cmd,
  input  wire logic      occ,
  input  wire logic      left_kept,
  input  wire entry_t    left_ent,
  input  wire entry_t    right_ent,
  input  wire entry_t    new_ent,
  output entry_t         ent,
  output logic           keep
);

  entry_t ent_r;
  entry_t ent_nxt;

  // an occupied slot not later than the new deadline stays put
  assign keep = occ && (ent_r.deadline <= new_ent.deadline);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.insert && !keep) begin
      ent_nxt = left_kept ? new_ent : left_ent;
    end else if (cmd.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

/* hdl/deadline_timer_queue.sv */
`default_nettype none
// Each input beat is captured into the item registers, and its result beats then pass
//   through the single result register once that register is free.
// A new input beat is stalled until the last one is done: an add emits one beat; a tick
//   emits one per expired event (at most MAX_OUT), or a single "none" when nothing is due.
// Each pop of an expired event shifts the cell chain by one cell.
// Reset (rst_n low, synchronous) empties the queue and drops pending beats;
//   entry storage is not cleared.
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [31:0]        in_now,
  input  wire logic [31:0]        in_delay,
  input  wire logic signed [31:0] in_client_id,
  input  wire logic [15:0]        in_tag,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic signed [31:0]      out_client_id_res,
  output logic [15:0]             out_tag_res,
  output logic [31:0]             out_deadline,
  output logic                    out_last
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POP_W-1:0]  npop_r, npop_nxt;

  // captured item; deadline sum is formed on the way in
  logic              op_r, op_nxt;
  logic [31:0]       now_r, now_nxt;
  entry_t            item_r, item_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [31:0]       out_cid_r, out_cid_nxt;
  logic [15:0]       out_tag_r, out_tag_nxt;
  logic [31:0]       out_dl_r, out_dl_nxt;
  logic              out_last_r, out_last_nxt;

  entry_t            ent [DEPTH];
  logic [DEPTH-1:0]  keep;
  logic [DEPTH-1:0]  occ;
  cell_cmd_t         cmd;

  logic              in_fire;
  logic              out_free;
  logic              go;
  logic              full;
  logic              head_due;
  logic              next_due;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign go       = (state_r == ST_EXEC) && out_free;
  assign full     = (count_r == CNT_W'(DEPTH));

  // head expires on a plain unsigned compare; the second cell tells whether
  // this pop is the final one of the tick
  assign head_due = (count_r != '0) && (ent[0].deadline < now_r) &&
                    (npop_r < POP_W'(MAX_OUT));
  assign next_due = (count_r > CNT_W'(1)) && (ent[1].deadline < now_r) &&
                    (npop_r < POP_W'(MAX_OUT - 1));

  assign cmd.insert = go && !op_r && !full;
  assign cmd.pop    = go && op_r && head_due;

  // chain of cells, kept sorted with the earliest deadline in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_r > CNT_W'(i));

    dtq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .left_kept ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_ent  (ent[(i == 0) ? 0 : i - 1]),
      .right_ent (ent[(i == DEPTH - 1) ? i : i + 1]),
      .new_ent   (item_r),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    npop_nxt      = npop_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_cid_nxt   = out_cid_r;
    out_tag_nxt   = out_tag_r;
    out_dl_nxt    = out_dl_r;
    out_last_nxt  = out_last_r;

    if (in_fire) begin
      // capture the beat and form the deadline, modulo 2^32
      op_nxt            = in_op;
      now_nxt           = in_now;
      item_nxt.deadline = in_now + in_delay;
      item_nxt.client   = $unsigned(in_client_id);
      item_nxt.tag      = in_tag;
      npop_nxt          = '0;
      state_nxt         = ST_EXEC;
    end

    if (go) begin
      out_valid_nxt = 1'b1;
      if (!op_r) begin
        out_kind_nxt = full ? KIND_FULL : KIND_ADDED;
        out_cid_nxt  = '0;
        out_tag_nxt  = item_r.tag;
        out_dl_nxt   = item_r.deadline;
        out_last_nxt = 1'b1;
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end else if (head_due) begin
        // emit the head and advance the chain one cell
        out_kind_nxt = KIND_EXPIRED;
        out_cid_nxt  = ent[0].client;
        out_tag_nxt  = ent[0].tag;
        out_dl_nxt   = ent[0].deadline;
        out_last_nxt = !next_due;
        count_nxt    = count_r - CNT_W'(1);
        npop_nxt     = npop_r + POP_W'(1);
        if (!next_due) begin
          state_nxt = ST_IDLE;
        end
      end else begin
        // nothing due on this tick
        out_kind_nxt = KIND_NONE;
        out_cid_nxt  = '0;
        out_tag_nxt  = '0;
        out_dl_nxt   = '0;
        out_last_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      npop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      npop_r      <= npop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    item_r     <= item_nxt;
    out_kind_r <= out_kind_nxt;
    out_cid_r  <= out_cid_nxt;
    out_tag_r  <= out_tag_nxt;
    out_dl_r   <= out_dl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_client_id_res = $signed(out_cid_r);
  assign out_tag_res       = out_tag_r;
  assign out_deadline      = out_dl_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (ent[0].deadline <= ent[1].deadline))
    else $error("head cells out of deadline order");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not drop the count by one");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !op_r && full) |=> (count_r == $past(count_r)))
    else $error("rejected add changed the queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_dl_r) && $stable(out_kind_r)))
    else $error("stalled result beat overwritten");
`endif

endmodule
`default_nettype wire
